FILE: src/ptnb_pkg.sv
package ptnb_pkg;

    localparam int unsigned FOUND_WIDTH = 31;
    localparam int unsigned FIELD_WIDTH = 32;

    typedef struct packed {
        logic                   action;
        logic [FIELD_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic                   is_prime;
        logic [FOUND_WIDTH-1:0] prime_found;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_INIT,
        ST_DIV,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic dec_cand;
        logic set_div2;
        logic inc_div;
        logic div_start;
        logic div_step;
        logic out_load;
        logic res_flag;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic negative;
        logic lt_two;
        logic le_two;
        logic div_last;
        logic d_gt_q;
        logic rem_zero;
    } status_t;

endpackage

FILE: src/ptnb_datapath.sv
module ptnb_datapath
    import ptnb_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic    clk,
    input  req_t    req_data,
    input  cmd_t    cmd,
    output status_t status,
    output rsp_t    rsp_data
);

    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam logic [VALUE_WIDTH-1:0] TWO = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

    logic                   action_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] cand_reg;
    logic [VALUE_WIDTH-1:0] div_reg;
    logic [VALUE_WIDTH-1:0] num_reg;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [CW-1:0]          cnt_reg;
    rsp_t                   rsp_data_reg;

    logic [VALUE_WIDTH+FIELD_WIDTH-1:0] value_ext;
    logic [VALUE_WIDTH+FOUND_WIDTH-1:0] found_ext;
    logic [VALUE_WIDTH:0]               rem_sh;
    logic [VALUE_WIDTH:0]               rem_diff;
    logic                               fits;
    logic [VALUE_WIDTH-1:0]             rem_next;
    rsp_t                               rsp_data_next;

    assign value_ext = {{VALUE_WIDTH{1'b0}}, req_data.value};
    assign found_ext = {{FOUND_WIDTH{1'b0}}, cand_reg};

    assign rem_sh   = {rem_reg, num_reg[VALUE_WIDTH-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign fits     = rem_sh >= {1'b0, div_reg};
    assign rem_next = fits ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];

    always_comb
    begin
        rsp_data_next.is_prime    = cmd.res_flag;
        rsp_data_next.prime_found = (cmd.res_flag && action_reg) ?
                                    found_ext[FOUND_WIDTH-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= req_data.action;
            neg_reg    <= value_ext[VALUE_WIDTH-1];
            cand_reg   <= value_ext[VALUE_WIDTH-1:0];
        end
        else if (cmd.dec_cand)
        begin
            cand_reg <= cand_reg - ONE;
        end

        if (cmd.set_div2)
        begin
            div_reg <= TWO;
        end
        else if (cmd.inc_div)
        begin
            div_reg <= div_reg + ONE;
        end

        if (cmd.div_start)
        begin
            num_reg <= cand_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[VALUE_WIDTH-2:0], fits};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg + CW'(1);
        end

        if (cmd.out_load)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign status.action   = action_reg;
    assign status.negative = neg_reg;
    assign status.lt_two   = cand_reg < TWO;
    assign status.le_two   = cand_reg <= TWO;
    assign status.div_last = cnt_reg == CW'(VALUE_WIDTH - 1);
    assign status.d_gt_q   = div_reg > num_reg;
    assign status.rem_zero = rem_reg == '0;

    assign rsp_data = rsp_data_reg;

endmodule

FILE: src/ptnb_ctrl.sv
module ptnb_ctrl
    import ptnb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    rsp_stall,
    input  status_t status,
    output logic    req_stall,
    output logic    rsp_valid,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   res_flag_reg;
    logic   res_flag_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;
    logic   trivial;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign trivial  = status.negative ||
                      (!status.action && status.lt_two) ||
                      (status.action && status.le_two);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = trivial ? ST_FINISH : ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.d_gt_q)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.rem_zero && !(status.action && !status.le_two))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_DIV_INIT;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        res_flag_next = res_flag_reg;
        cmd.res_flag  = res_flag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = req_valid;
            end
            ST_SETUP:
            begin
                res_flag_next = 1'b0;
                if (!trivial)
                begin
                    cmd.dec_cand = status.action;
                    cmd.set_div2 = 1'b1;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CHECK:
            begin
                if (status.d_gt_q)
                begin
                    res_flag_next = 1'b1;
                end
                else if (status.rem_zero)
                begin
                    if (status.action && !status.le_two)
                    begin
                        cmd.dec_cand = 1'b1;
                        cmd.set_div2 = 1'b1;
                    end
                    else
                    begin
                        res_flag_next = 1'b0;
                    end
                end
                else
                begin
                    cmd.inc_div = 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.out_load = rsp_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_flag_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_flag_reg  <= res_flag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: src/prime_test_nearest_below.sv
// Sequence: a trivial operand goes from ST_SETUP straight to ST_FINISH; else each divisor
// passes ST_DIV_INIT, ST_DIV (serial remainder) and ST_CHECK, then ST_FINISH registers the response.
// Throughput: one transfer at a time; up to about 46341 divisors per candidate at
// 32 bits, repeated per candidate when searching downward.
// Reset: rst_n asynchronous, active low; clears the state machine and response valid,
// after which the block is ready at once.
module prime_test_nearest_below
    import ptnb_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp_data
);

    cmd_t    cmd;
    status_t status;

    ptnb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .cmd       (cmd)
    );

    ptnb_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .req_data (req_data),
        .cmd      (cmd),
        .status   (status),
        .rsp_data (rsp_data)
    );

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import ptnb_pkg::*;

    localparam logic ACT_TEST  = 1'b0;
    localparam logic ACT_BELOW = 1'b1;

    localparam int unsigned STALL_LIMIT = 5_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 18;

    class prime_verdict_board;
        rsp_t        awaited_verdicts[$];
        int unsigned errors;
        int unsigned tests_noted;
        int unsigned searches_noted;
        int unsigned verdicts_checked;
        int unsigned primes_seen;

        function bit has_no_divisor(longint unsigned v);
            longint unsigned d;
            if (v < 2)
                return 1'b0;
            for (d = 2; d <= v / d; d++)
            begin
                if (v % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function longint unsigned largest_prime_under(longint unsigned v);
            longint unsigned c;
            if (v <= 2)
                return 0;
            for (c = v - 1; c >= 2; c--)
            begin
                if (has_no_divisor(c))
                    return c;
            end
            return 0;
        endfunction

        function void note_request(req_t item);
            rsp_t            verdict;
            longint unsigned mag;
            longint unsigned found;
            verdict = '0;
            mag = longint'(item.value);
            if (item.action == ACT_TEST)
                tests_noted++;
            else
                searches_noted++;
            if (!item.value[FIELD_WIDTH-1])
            begin
                if (item.action == ACT_TEST)
                begin
                    verdict.is_prime = has_no_divisor(mag);
                end
                else
                begin
                    found = largest_prime_under(mag);
                    verdict.is_prime = (found != 0);
                    verdict.prime_found = found[FOUND_WIDTH-1:0];
                end
            end
            awaited_verdicts.push_back(verdict);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited_verdicts.size() == 0)
            begin
                $error("unexpected result: is_prime %0d prime_found %0d",
                       got.is_prime, got.prime_found);
                errors++;
                return;
            end
            want = awaited_verdicts.pop_front();
            verdicts_checked++;
            if (got.is_prime)
                primes_seen++;
            if (got.is_prime !== want.is_prime)
            begin
                $error("is_prime: expected %0d, actual %0d", want.is_prime, got.is_prime);
                errors++;
            end
            if (got.prime_found !== want.prime_found)
            begin
                $error("prime_found: expected %0d, actual %0d",
                       want.prime_found, got.prime_found);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return awaited_verdicts.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;

    prime_verdict_board board = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    prime_test_nearest_below dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                board.note_request(req_data);
            if (rsp_valid && !rsp_stall)
                board.check_response(rsp_data);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic send_item(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic send_op(input logic act, input logic [FIELD_WIDTH-1:0] val);
        req_t item;
        item.action = act;
        item.value  = val;
        send_item(item);
    endtask

    function automatic req_t random_item();
        req_t        item;
        int unsigned pick;
        item.action = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 40)
            item.value = $urandom_range(300);
        else if (pick < 65)
            item.value = $urandom_range(5000);
        else if (pick < 75)
            item.value = $urandom_range(100000);
        else if (pick < 90)
            item.value = $urandom() | 32'h8000_0000;
        else
            item.value = $urandom_range(4) - 32'd2;
        return item;
    endfunction

    initial
    begin
        int unsigned sender_idle[4];
        int unsigned receiver_stall[4];
        sender_idle    = '{0, 76, 0, 36};
        receiver_stall = '{0, 0, 76, 36};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(ACT_TEST, 32'd0);
        send_op(ACT_TEST, 32'd1);
        send_op(ACT_TEST, 32'd2);
        send_op(ACT_TEST, 32'd3);
        send_op(ACT_TEST, 32'd4);
        send_op(ACT_TEST, 32'd25);
        send_op(ACT_TEST, 32'd97);
        send_op(ACT_TEST, 32'd65537);
        send_op(ACT_TEST, 32'hFFFF_FFFF);
        send_op(ACT_TEST, 32'h8000_0000);
        send_op(ACT_TEST, 32'h7FFF_FFFE);
        send_op(ACT_TEST, 32'h7FFF_FFFF);
        send_op(ACT_BELOW, 32'h8000_0000);
        send_op(ACT_BELOW, 32'hFFFF_FFFF);
        send_op(ACT_BELOW, 32'd0);
        send_op(ACT_BELOW, 32'd1);
        send_op(ACT_BELOW, 32'd2);
        send_op(ACT_BELOW, 32'd3);
        send_op(ACT_BELOW, 32'd4);
        send_op(ACT_BELOW, 32'd100);
        send_op(ACT_BELOW, 32'd1000000);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = sender_idle[p];
            recv_stall_pct = receiver_stall[p];
            repeat (PHASE_ITEMS) send_item(random_item());
            if (p == 0)
            begin
                // hold the response side while transfers keep coming
                hold_request = 1'b1;
                repeat (6) send_op(1'($urandom_range(1)), $urandom_range(60));
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d primality tests and %0d downward searches, %0d results checked",
                 board.tests_noted, board.searches_noted, board.verdicts_checked);
        $display("%0d results reported a prime; idle, stall and long hold-off phases run",
                 board.primes_seen);
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
src/ptnb_pkg.sv
src/ptnb_datapath.sv
src/ptnb_ctrl.sv
src/prime_test_nearest_below.sv
dv/tb_top.sv
